// ===== rtl/core/pitch_quantizer_equal_temperament_core_defines.svh =====
// Assertion macros for the pitch quantizer core and its checker.
`ifndef PITCH_QUANTIZER_EQUAL_TEMPERAMENT_CORE_DEFINES_SVH
`define PITCH_QUANTIZER_EQUAL_TEMPERAMENT_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define PQET_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pqet: same-cycle check failed");

// Next-cycle implication, off while rst is high.
`define PQET_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pqet: next-cycle check failed");

`endif

// ===== rtl/core/pqet_pkg.sv =====
// Shared constants, types and tables of the pitch quantizer core.
package pqet_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int LOG_TABLE_BITS = 10;
   localparam int LOG_INT_W      = 6;
   localparam int LOG_W          = LOG_INT_W + LOG_TABLE_BITS;
   localparam int EXP_BITS       = 24;
   localparam int K_W            = 16;
   localparam int K_MAG_W        = 14;
   localparam int Q_W            = 16;
   localparam int DIV_STEPS      = K_MAG_W + EXP_BITS;
   localparam int DIV_PER_STAGE  = 2;
   localparam int DIV_STAGES     = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
   localparam int MANT_SHIFT     = 30;
   localparam int CSR_IDX_W      = 8;

   localparam logic [31:0] ONE_Q30       = 32'h4000_0000;
   localparam logic [31:0] REF_FREQ_RST  = 32'd28835840;
   localparam logic [7:0]  STEPS_RST     = 8'd12;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_REF_FREQ = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS    = 8'd1;

   // Pipeline control that travels with each item
   typedef struct packed {
      logic valid;
      logic zero;
   } ctl_type;

   typedef logic [31:0] root_table_type [EXP_BITS];

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bt;
      rem = v;
      res = '0;
      bt  = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bt) begin
            rem = rem - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // Q2.30 roots 2^(2^-i), i = 1 .. EXP_BITS, each rounded down
   function automatic root_table_type build_roots();
      root_table_type tbl;
      logic [63:0]    root;
      root = isqrt64(64'd2 << 60);
      for (int i = 0; i < EXP_BITS; i++) begin
         tbl[i] = root[31:0];
         root   = isqrt64(root << 30);
      end
      return tbl;
   endfunction

   localparam root_table_type EXP_ROOTS = build_roots();

endpackage

// ===== rtl/core/pqet_channels.sv =====
// Handshake interfaces of the pitch quantizer core: request, response, register write.
interface pqet_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] in_freq;
   modport source (output valid, output in_freq, input ready);
   modport sink   (input valid, input in_freq, output ready);
endinterface

interface pqet_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] quantized_freq;
   modport source (output valid, output quantized_freq, input ready);
   modport sink   (input valid, input quantized_freq, output ready);
endinterface

interface pqet_csr_if;
   import pqet_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [31:0]          data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/pitch_quantizer_equal_temperament_core.sv =====
// Equal-temperament pitch quantizer: top level with registers, step rounding and scaling.
//
// Channels: req_ch carries one signed Q16.16 frequency per item, of which only
// the magnitude counts. rsp_ch returns one unsigned Q16.16 frequency per item:
// the nearest pitch on the grid anchored at reference_freq with
// steps_per_octave steps per octave, saturating at all ones. csr_ch writes
// register 0 (reference_freq) and register 1 (steps_per_octave); it is always
// ready, and writes belong to times when no item is in flight.
// Path from acceptance to the result on rsp_ch: the bit-serial logarithms (one
// squaring multiplier per bit), the step rounding, the 2-bit-per-stage divider,
// the root product (one multiplier per fraction bit), the reference product and
// the final shift and rounding into the output register.
// Throughput: one item per cycle while rsp_ch takes its items; every stage is a register stage.
// Stall: when rsp_ch holds an item that is not taken, the whole pipeline
// freezes and req_ch.ready drops; nothing is lost or repeated.
// Reset: clears all valid bits and loads 440.0 Hz and 12 steps per octave.
module pitch_quantizer_equal_temperament_core (
   input  logic      clock,
   input  logic      reset,
   pqet_req_if.sink   req_ch,
   pqet_rsp_if.source rsp_ch,
   pqet_csr_if.sink   csr_ch
);
   import pqet_pkg::*;

   logic [31:0] ref_freq_ff;
   logic [7:0]  steps_ff;
   logic        adv;
   logic [31:0] raw;
   logic [31:0] mag;
   ctl_type     ctl_entry;

   ctl_type               ctl_log;
   logic signed [LOG_W-1:0] la;
   logic signed [LOG_W-1:0] lr;

   ctl_type               ctl_k_ff;
   logic signed [K_W-1:0] k_ff;
   logic signed [LOG_W:0] d;
   logic signed [LOG_W+9:0] td;
   logic signed [LOG_W+9:0] kr;

   ctl_type               ctl_div;
   logic signed [Q_W-1:0] q_div;
   logic [EXP_BITS-1:0]   e_div;

   ctl_type               ctl_exp;
   logic [31:0]           mant;
   logic signed [Q_W-1:0] q_exp;

   ctl_type               ctl_p_ff;
   logic [63:0]           p_ff;
   logic signed [Q_W-1:0] q_p_ff;

   ctl_type               ctl_f_ff;
   logic [31:0]           res_ff;
   logic [31:0]           res_in;

   // Advance the whole pipeline unless the output item is held
   assign adv          = !ctl_f_ff.valid || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign csr_ch.ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_freq_ff <= REF_FREQ_RST;
         steps_ff    <= STEPS_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_REF_FREQ: ref_freq_ff <= csr_ch.data;
            CSR_STEPS:    steps_ff    <= csr_ch.data[7:0];
            default:      ;
         endcase
      end
   end

   // Magnitude and zero detection at entry
   assign raw             = req_ch.in_freq;
   assign mag             = raw[31] ? (32'd0 - raw) : raw;
   assign ctl_entry.valid = req_ch.valid;
   assign ctl_entry.zero  = (mag == '0) || (ref_freq_ff == '0) || (steps_ff == '0);

   pqet_log2 u_log2 (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .ctl_in  (ctl_entry),
      .a_in    (mag),
      .b_in    (ref_freq_ff),
      .ctl_out (ctl_log),
      .la_out  (la),
      .lb_out  (lr)
   );

   // Round the scaled log difference to a step count, ties upward
   assign d  = LOG_W'(la) - LOG_W'(lr) + (LOG_W+1)'(0);
   always_comb begin
      td = $signed({1'b0, steps_ff}) * d;
      kr = (td + (LOG_W+10)'(1 << (LOG_TABLE_BITS - 1))) >>> LOG_TABLE_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) ctl_k_ff <= '0;
      else if (adv) ctl_k_ff <= ctl_log;
   end

   always_ff @(posedge clock) begin
      if (adv) k_ff <= kr[K_W-1:0];
   end

   pqet_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .ctl_in  (ctl_k_ff),
      .k_in    (k_ff),
      .t_in    (steps_ff),
      .ctl_out (ctl_div),
      .q_out   (q_div),
      .e_out   (e_div)
   );

   pqet_exp2 u_exp2 (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .ctl_in   (ctl_div),
      .e_in     (e_div),
      .q_in     (q_div),
      .ctl_out  (ctl_exp),
      .mant_out (mant),
      .q_out    (q_exp)
   );

   // Scale the mantissa by the reference
   always_ff @(posedge clock) begin
      if (reset) ctl_p_ff <= '0;
      else if (adv) ctl_p_ff <= ctl_exp;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff   <= ref_freq_ff * mant;
         q_p_ff <= q_exp;
      end
   end

   // Shift by octave, round half upward, saturate
   always_comb begin
      logic signed [Q_W:0] s;
      logic [Q_W:0]        n;
      logic [4:0]          shl;
      logic [5:0]          shr;
      logic [64:0]         sum;
      logic [64:0]         down;
      s      = {q_p_ff[Q_W-1], q_p_ff} - (Q_W+1)'(MANT_SHIFT);
      n      = (Q_W+1)'(0) - s;
      shl    = s[4:0];
      shr    = n[5:0];
      sum    = '0;
      down   = '0;
      res_in = '0;
      if (ctl_p_ff.zero) begin
         res_in = '0;
      end else if (!s[Q_W]) begin
         if (s >= (Q_W+1)'(32)) begin
            res_in = '1;
         end else if ((p_ff >> (6'd32 - {1'b0, shl})) != '0) begin
            res_in = '1;
         end else begin
            res_in = p_ff[31:0] << shl;
         end
      end else if (n >= (Q_W+1)'(64)) begin
         res_in = '0;
      end else begin
         sum  = {1'b0, p_ff} + (65'd1 << (shr - 6'd1));
         down = sum >> shr;
         res_in = (down[64:32] != '0) ? '1 : down[31:0];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) ctl_f_ff <= '0;
      else if (adv) ctl_f_ff <= ctl_p_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) res_ff <= res_in;
   end

   assign rsp_ch.valid          = ctl_f_ff.valid;
   assign rsp_ch.quantized_freq = res_ff;

endmodule

// ===== rtl/core/pqet_log2.sv =====
// Pipelined base-2 logarithm of the input magnitude and the reference, one bit per stage.
module pqet_log2 (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  pqet_pkg::ctl_type                ctl_in,
   input  logic [31:0]                      a_in,
   input  logic [31:0]                      b_in,
   output pqet_pkg::ctl_type                ctl_out,
   output logic signed [pqet_pkg::LOG_W-1:0] la_out,
   output logic signed [pqet_pkg::LOG_W-1:0] lb_out
);
   import pqet_pkg::*;

   localparam int STG = LOG_TABLE_BITS + 1;

   ctl_type                   ctl_ff [STG];
   logic [31:0]               ma_ff  [STG];
   logic [31:0]               mb_ff  [STG];
   logic [LOG_INT_W-1:0]      ea_ff  [STG];
   logic [LOG_INT_W-1:0]      eb_ff  [STG];
   logic [LOG_TABLE_BITS-1:0] fa_ff  [STG];
   logic [LOG_TABLE_BITS-1:0] fb_ff  [STG];

   // {exponent minus fraction bits, mantissa with msb at bit 31}
   function automatic logic [LOG_INT_W+31:0] normalize(input logic [31:0] v);
      logic [4:0]           msb;
      logic [31:0]          m;
      logic [LOG_INT_W-1:0] ex;
      msb = '0;
      for (int i = 1; i < 32; i++) begin
         if (v[i]) msb = 5'(i);
      end
      m  = v << (5'd31 - msb);
      ex = {1'b0, msb} - LOG_INT_W'(FRAC_BITS);
      return {ex, m};
   endfunction

   // Square, then renormalize: {fraction bit, new mantissa}
   function automatic logic [32:0] sq_step(input logic [31:0] m);
      logic [63:0] p;
      logic [32:0] h;
      p = m * m;
      h = p[63:31];
      if (h[32]) return {1'b1, h[32:1]};
      return {1'b0, h[31:0]};
   endfunction

   // Normalize both operands
   always_ff @(posedge clock) begin
      if (reset) ctl_ff[0] <= '0;
      else if (adv) ctl_ff[0] <= ctl_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         {ea_ff[0], ma_ff[0]} <= normalize(a_in);
         {eb_ff[0], mb_ff[0]} <= normalize(b_in);
         fa_ff[0] <= '0;
         fb_ff[0] <= '0;
      end
   end

   // One fraction bit per stage
   for (genvar i = 1; i < STG; i++) begin : g_sq
      logic [32:0] sq_a_in;
      logic [32:0] sq_b_in;

      always_comb begin
         sq_a_in = sq_step(ma_ff[i-1]);
         sq_b_in = sq_step(mb_ff[i-1]);
      end

      always_ff @(posedge clock) begin
         if (reset) ctl_ff[i] <= '0;
         else if (adv) ctl_ff[i] <= ctl_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ma_ff[i] <= sq_a_in[31:0];
            mb_ff[i] <= sq_b_in[31:0];
            fa_ff[i] <= {fa_ff[i-1][LOG_TABLE_BITS-2:0], sq_a_in[32]};
            fb_ff[i] <= {fb_ff[i-1][LOG_TABLE_BITS-2:0], sq_b_in[32]};
            ea_ff[i] <= ea_ff[i-1];
            eb_ff[i] <= eb_ff[i-1];
         end
      end
   end

   assign ctl_out = ctl_ff[STG-1];
   assign la_out  = {ea_ff[STG-1], fa_ff[STG-1]};
   assign lb_out  = {eb_ff[STG-1], fb_ff[STG-1]};

endmodule

// ===== rtl/core/pqet_divider.sv =====
// Pipelined floor division of the step count by the steps per octave, with fraction bits.
module pqet_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  pqet_pkg::ctl_type                 ctl_in,
   input  logic signed [pqet_pkg::K_W-1:0]   k_in,
   input  logic [7:0]                        t_in,
   output pqet_pkg::ctl_type                 ctl_out,
   output logic signed [pqet_pkg::Q_W-1:0]   q_out,
   output logic [pqet_pkg::EXP_BITS-1:0]     e_out
);
   import pqet_pkg::*;

   ctl_type              ctl_a_ff;
   logic                 neg_a_ff;
   logic [DIV_STEPS-1:0] w_a_ff;
   logic [K_W-1:0]       kabs;

   ctl_type              ctl_ff  [DIV_STAGES];
   logic                 neg_ff  [DIV_STAGES];
   logic                 ranz_ff [DIV_STAGES];
   logic [7:0]           rem_ff  [DIV_STAGES];
   logic [DIV_STEPS-1:0] w_ff    [DIV_STAGES];

   ctl_type               ctl_o_ff;
   logic signed [Q_W-1:0] q_o_ff;
   logic [EXP_BITS-1:0]   e_o_ff;

   // Take the magnitude, keep the sign
   assign kabs = k_in[K_W-1] ? (K_W'(0) - k_in) : k_in;

   always_ff @(posedge clock) begin
      if (reset) ctl_a_ff <= '0;
      else if (adv) ctl_a_ff <= ctl_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_a_ff <= k_in[K_W-1];
         w_a_ff   <= {kabs[K_MAG_W-1:0], EXP_BITS'(0)};
      end
   end

   // Restoring division, DIV_PER_STAGE quotient bits per stage
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      ctl_type              ctl_p;
      logic                 neg_p;
      logic                 ranz_p;
      logic [7:0]           rem_p;
      logic [DIV_STEPS-1:0] w_p;
      logic                 ranz_in;
      logic [7:0]           rem_in;
      logic [DIV_STEPS-1:0] w_in;

      if (j == 0) begin : g_first
         assign ctl_p  = ctl_a_ff;
         assign neg_p  = neg_a_ff;
         assign ranz_p = 1'b0;
         assign rem_p  = '0;
         assign w_p    = w_a_ff;
      end else begin : g_next
         assign ctl_p  = ctl_ff[j-1];
         assign neg_p  = neg_ff[j-1];
         assign ranz_p = ranz_ff[j-1];
         assign rem_p  = rem_ff[j-1];
         assign w_p    = w_ff[j-1];
      end

      always_comb begin
         logic [8:0] tmp;
         logic       qb;
         w_in    = w_p;
         rem_in  = rem_p;
         ranz_in = ranz_p;
         for (int b = 0; b < DIV_PER_STAGE; b++) begin
            if (j * DIV_PER_STAGE + b < DIV_STEPS) begin
               tmp = {rem_in, w_in[DIV_STEPS-1]};
               if (tmp >= {1'b0, t_in}) begin
                  tmp = tmp - {1'b0, t_in};
                  qb  = 1'b1;
               end else begin
                  qb  = 1'b0;
               end
               rem_in = tmp[7:0];
               w_in   = {w_in[DIV_STEPS-2:0], qb};
               // remainder of the integer part
               if (j * DIV_PER_STAGE + b == K_MAG_W - 1) ranz_in = (rem_in != '0);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) ctl_ff[j] <= '0;
         else if (adv) ctl_ff[j] <= ctl_p;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            neg_ff[j]  <= neg_p;
            ranz_ff[j] <= ranz_in;
            rem_ff[j]  <= rem_in;
            w_ff[j]    <= w_in;
         end
      end
   end

   // Turn the magnitude result into floor quotient and fraction of the remainder
   always_ff @(posedge clock) begin
      if (reset) ctl_o_ff <= '0;
      else if (adv) ctl_o_ff <= ctl_ff[DIV_STAGES-1];
   end

   always_ff @(posedge clock) begin
      logic [Q_W-1:0]      qext;
      logic [EXP_BITS-1:0] fa;
      logic [EXP_BITS:0]   ediff;
      logic                neg;
      logic                ranz;
      qext  = Q_W'(w_ff[DIV_STAGES-1][DIV_STEPS-1 -: K_MAG_W]);
      fa    = w_ff[DIV_STAGES-1][EXP_BITS-1:0];
      neg   = neg_ff[DIV_STAGES-1];
      ranz  = ranz_ff[DIV_STAGES-1];
      ediff = {1'b1, EXP_BITS'(0)} - {1'b0, fa}
            - (EXP_BITS+1)'(rem_ff[DIV_STAGES-1] != '0);
      if (adv) begin
         if (neg && ranz) begin
            q_o_ff <= Q_W'(0) - qext - Q_W'(1);
            e_o_ff <= ediff[EXP_BITS-1:0];
         end else if (neg) begin
            q_o_ff <= Q_W'(0) - qext;
            e_o_ff <= fa;
         end else begin
            q_o_ff <= qext;
            e_o_ff <= fa;
         end
      end
   end

   assign ctl_out = ctl_o_ff;
   assign q_out   = q_o_ff;
   assign e_out   = e_o_ff;

endmodule

// ===== rtl/core/pqet_exp2.sv =====
// Pipelined 2^fraction as a product of square roots of two, one root per stage.
module pqet_exp2 (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  pqet_pkg::ctl_type               ctl_in,
   input  logic [pqet_pkg::EXP_BITS-1:0]   e_in,
   input  logic signed [pqet_pkg::Q_W-1:0] q_in,
   output pqet_pkg::ctl_type               ctl_out,
   output logic [31:0]                     mant_out,
   output logic signed [pqet_pkg::Q_W-1:0] q_out
);
   import pqet_pkg::*;

   ctl_type               ctl_ff [EXP_BITS];
   logic [31:0]           m_ff   [EXP_BITS];
   logic [EXP_BITS-1:0]   e_ff   [EXP_BITS];
   logic signed [Q_W-1:0] q_ff   [EXP_BITS];

   for (genvar i = 0; i < EXP_BITS; i++) begin : g_exp
      ctl_type               ctl_p;
      logic [31:0]           m_p;
      logic [EXP_BITS-1:0]   e_p;
      logic signed [Q_W-1:0] q_p;
      logic [63:0]           prod;
      logic [31:0]           m_in;

      if (i == 0) begin : g_first
         assign ctl_p = ctl_in;
         assign m_p   = ONE_Q30;
         assign e_p   = e_in;
         assign q_p   = q_in;
      end else begin : g_next
         assign ctl_p = ctl_ff[i-1];
         assign m_p   = m_ff[i-1];
         assign e_p   = e_ff[i-1];
         assign q_p   = q_ff[i-1];
      end

      // Multiply in the root when its fraction bit is set
      always_comb begin
         prod = m_p * EXP_ROOTS[i];
         m_in = e_p[EXP_BITS-1-i] ? prod[61:30] : m_p;
      end

      always_ff @(posedge clock) begin
         if (reset) ctl_ff[i] <= '0;
         else if (adv) ctl_ff[i] <= ctl_p;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            m_ff[i] <= m_in;
            e_ff[i] <= e_p;
            q_ff[i] <= q_p;
         end
      end
   end

   assign ctl_out  = ctl_ff[EXP_BITS-1];
   assign mant_out = m_ff[EXP_BITS-1];
   assign q_out    = q_ff[EXP_BITS-1];

endmodule

// ===== rtl/core/pqet_checker.sv =====
// Port-level checks of the pitch quantizer core, bound to its top level.
`include "pitch_quantizer_equal_temperament_core_defines.svh"

module pqet_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_quantized_freq
);

   // A held output item freezes the pipeline, so no new item is taken
   `PQET_ASSERT_IMPLY(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // An empty output stage always lets the next item in
   `PQET_ASSERT_IMPLY(a_empty_takes_req, clock, reset, !rsp_valid, req_ready)

   // Reset drops every item in flight
   `PQET_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

   // Hold a stalled item and its value
   `PQET_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_quantized_freq))

   logic unused_req_valid;
   assign unused_req_valid = req_valid;

endmodule

bind pitch_quantizer_equal_temperament_core pqet_checker u_pqet_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_quantized_freq (rsp_ch.quantized_freq)
);
